/* rtl/fta_pkg.sv */
package fta_pkg;

    // Field widths of the request, response and configuration channels.
    localparam int POS_W   = 10;
    localparam int DELTA_W = 16;
    localparam int SIZE_W  = 11;
    localparam int CELL_W  = 32;

    // Walk index width. It covers the largest upward step that can follow
    // a position at the largest size_in_use value.
    localparam int WALK_W = 13;

    // Value of size_in_use after reset.
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    // Command codes.
    typedef enum logic {
        CMD_ADD = 1'b0,
        CMD_SUM = 1'b1
    } cmd_t;

    // One request as the walker latches it.
    typedef struct packed {
        cmd_t                       command;
        logic [POS_W-1:0]           position;
        logic [POS_W-1:0]           left_end;
        logic signed [DELTA_W-1:0]  delta;
    } item_t;

    // Finished range sum handed to the output register.
    typedef struct packed {
        logic                       valid;
        logic signed [CELL_W-1:0]   range_sum;
    } result_t;

endpackage

/* rtl/fta_channels.sv */
// Request channel: one add or range-sum command.
interface fta_req_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  command;
    logic [fta_pkg::POS_W-1:0]             position;
    logic [fta_pkg::POS_W-1:0]             left_end;
    logic signed [fta_pkg::DELTA_W-1:0]    delta;

    modport source (output valid, command, position, left_end, delta, input ready);
    modport sink   (input valid, command, position, left_end, delta, output ready);
endinterface

// Response channel: one range sum.
interface fta_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [fta_pkg::CELL_W-1:0]     range_sum;

    modport source (output valid, range_sum, input ready);
    modport sink   (input valid, range_sum, output ready);
endinterface

// Configuration write channel for size_in_use.
interface fta_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [fta_pkg::SIZE_W-1:0]            size_in_use;

    modport source (output valid, size_in_use, input ready);
    modport sink   (input valid, size_in_use, output ready);
endinterface

/* rtl/fta_cell_ram.sv */
module fta_cell_ram #(
    parameter int DEPTH  = 1026,
    parameter int ADDR_W = 11
) (
    input  logic                               clk,
    input  logic                               wr_en,
    input  logic [ADDR_W-1:0]                  wr_addr,
    input  logic [fta_pkg::CELL_W-1:0]         wr_data,
    input  logic                               rd_en,
    input  logic [ADDR_W-1:0]                  rd_addr,
    output logic [fta_pkg::CELL_W-1:0]         rd_data
);

    logic [fta_pkg::CELL_W-1:0] mem [DEPTH];
    logic [fta_pkg::CELL_W-1:0] rd_data_reg;

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/fta_walker.sv */
module fta_walker #(
    parameter int MAX_POSITIONS = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  fta_pkg::item_t                 req_item,
    input  logic [fta_pkg::SIZE_W-1:0]     size_in_use,
    input  logic                           out_free,
    output fta_pkg::result_t               result
);

    localparam int CELL_COUNT = MAX_POSITIONS + 2;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CMP_W      = (ADDR_W + 1 > fta_pkg::WALK_W) ? ADDR_W + 1 : fta_pkg::WALK_W;
    localparam int WALK_W     = fta_pkg::WALK_W;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_WALK   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t                         state_reg, state_next;
    logic [ADDR_W-1:0]              clr_reg, clr_next;
    fta_pkg::cmd_t                  cmd_reg, cmd_next;
    logic [fta_pkg::POS_W-1:0]      left_reg, left_next;
    logic [fta_pkg::CELL_W-1:0]     delta_reg, delta_next;
    logic [WALK_W-1:0]              walk_reg, walk_next;
    logic                           phase_reg, phase_next;
    logic [fta_pkg::CELL_W-1:0]     acc_reg, acc_next;
    logic                           pend_valid_reg;
    logic [ADDR_W-1:0]              pend_addr_reg;
    logic                           pend_sub_reg;

    logic [WALK_W-1:0]              lowbit;
    logic [WALK_W-1:0]              walk_up;
    logic [WALK_W-1:0]              walk_dn;
    logic [WALK_W-1:0]              lim_p1;
    logic                           in_store;
    logic                           rd_en;
    logic [ADDR_W-1:0]              rd_addr;
    logic [fta_pkg::CELL_W-1:0]     rd_data;
    logic                           wr_en;
    logic [ADDR_W-1:0]              wr_addr;
    logic [fta_pkg::CELL_W-1:0]     wr_data;

    // Cell store.
    fta_cell_ram #(
        .DEPTH  (CELL_COUNT),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Index arithmetic: lowest set bit, next index up and down.
    assign lowbit  = walk_reg & (~walk_reg + WALK_W'(1));
    assign walk_up = walk_reg + lowbit;
    assign walk_dn = walk_reg & ~lowbit;
    assign in_store = CMP_W'(walk_reg) < CMP_W'(CELL_COUNT);
    assign rd_addr  = ADDR_W'(walk_reg);

    // Upper bound of an add walk: the clamped size plus one.
    always_comb
    begin
        if (32'(size_in_use) > 32'(MAX_POSITIONS))
        begin
            lim_p1 = WALK_W'(MAX_POSITIONS) + WALK_W'(1);
        end
        else
        begin
            lim_p1 = WALK_W'(size_in_use) + WALK_W'(1);
        end
    end

    // Sequencer: one cell read issued per cycle, its data used the next cycle.
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        cmd_next   = cmd_reg;
        left_next  = left_reg;
        delta_next = delta_reg;
        walk_next  = walk_reg;
        phase_next = phase_reg;
        acc_next   = acc_reg;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = pend_addr_reg;
        wr_data    = rd_data + delta_reg;
        req_ready  = 1'b0;
        result.valid     = 1'b0;
        result.range_sum = acc_reg;

        // Data of the read issued last cycle.
        if (pend_valid_reg)
        begin
            if (cmd_reg == fta_pkg::CMD_ADD)
            begin
                wr_en = 1'b1;
            end
            else if (pend_sub_reg)
            begin
                acc_next = acc_reg - rd_data;
            end
            else
            begin
                acc_next = acc_reg + rd_data;
            end
        end

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd_next   = req_item.command;
                    left_next  = req_item.left_end;
                    delta_next = fta_pkg::CELL_W'(req_item.delta);
                    walk_next  = WALK_W'(req_item.position) + WALK_W'(1);
                    phase_next = 1'b0;
                    acc_next   = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (cmd_reg == fta_pkg::CMD_ADD)
                begin
                    if (walk_reg <= lim_p1)
                    begin
                        rd_en     = 1'b1;
                        walk_next = walk_up;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (walk_reg != '0)
                begin
                    rd_en     = in_store;
                    walk_next = walk_dn;
                end
                else if (!phase_reg)
                begin
                    // Right prefix done; start the left prefix.
                    phase_next = 1'b1;
                    walk_next  = WALK_W'(left_reg);
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                result.valid = out_free;
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            pend_valid_reg <= rd_en;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        left_reg      <= left_next;
        delta_reg     <= delta_next;
        walk_reg      <= walk_next;
        phase_reg     <= phase_next;
        acc_reg       <= acc_next;
        pend_addr_reg <= rd_addr;
        pend_sub_reg  <= phase_reg;
    end

`ifndef SYNTHESIS
    // No cell is read while the clearing pass runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !rd_en)
        else $error("cell read during clearing pass");

    // An update writes back exactly the cell read in the cycle before.
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && state_reg != ST_CLEAR) |-> (wr_addr == $past(rd_addr) && $past(rd_en)))
        else $error("write-back address does not match the read");

    // A new request is taken only with no read in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> !pend_valid_reg)
        else $error("request accepted with a read in flight");

    // Only a range sum produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (cmd_reg == fta_pkg::CMD_SUM))
        else $error("result from an add command");
`endif

endmodule

/* rtl/fenwick_tree_add_and_range_sum_core.sv */
// Channel  Dir  Payload                                   Transfer
// req      in   command, position, left_end, delta        valid && ready
// rsp      out  range_sum                                 valid && ready
// cfg      in   size_in_use                               valid && ready (always ready)
//
// An add walks upward from position + 1, reading each cell and writing it back with delta added.
// A range sum walks downward from position + 1, then from left_end, and subtracts the second total.
// The cell memory's single read port sets the pace: one cell is read per cycle.
// After reset a clearing pass zeroes all MAX_POSITIONS + 2 cells; no request is taken during it.
// A waiting result sits in the output register; a sum stalls only when that register is full and rsp.ready is low.

module fenwick_tree_add_and_range_sum_core #(
    parameter int MAX_POSITIONS = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    fta_req_if.sink    req,
    fta_rsp_if.source  rsp,
    fta_cfg_if.sink    cfg
);

    fta_pkg::item_t                  req_item;
    fta_pkg::result_t                result;
    logic [fta_pkg::SIZE_W-1:0]      size_reg;
    logic                            out_valid_reg;
    logic signed [fta_pkg::CELL_W-1:0] out_sum_reg;
    logic                            out_free;

    // Pack the request fields.
    assign req_item.command  = fta_pkg::cmd_t'(req.command);
    assign req_item.position = req.position;
    assign req_item.left_end = req.left_end;
    assign req_item.delta    = req.delta;

    // Configuration register; writes are taken in any cycle.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= fta_pkg::SIZE_RESET;
        end
        else if (cfg.valid)
        begin
            size_reg <= cfg.size_in_use;
        end
    end

    // Walk sequencer and cell store.
    fta_walker #(
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_ready   (req.ready),
        .req_item    (req_item),
        .size_in_use (size_reg),
        .out_free    (out_free),
        .result      (result)
    );

    // Output register separating the response side from the walker.
    assign out_free = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= result.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            out_sum_reg <= result.range_sum;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.range_sum = out_sum_reg;

endmodule

/* test/fenwick_sum_checker.sv */
`timescale 1ns / 1ps

// Watches the request, response and configuration channels, keeps its own
// copy of the tree cells, and checks every returned range sum in order.
module fenwick_sum_checker #(
    parameter int POSITION_COUNT = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    fta_req_if          req,
    fta_rsp_if          rsp,
    fta_cfg_if          cfg,
    output int unsigned mismatch_count,
    output int unsigned sums_waiting
);

    localparam int CELL_COUNT = POSITION_COUNT + 2;
    localparam int REPORT_LIMIT = 10;

    logic [fta_pkg::CELL_W-1:0] cells [0:CELL_COUNT-1];
    logic [fta_pkg::SIZE_W-1:0] size_now;
    logic [fta_pkg::CELL_W-1:0] expected_sums [$];

    // Sum of the cells on the downward walk that starts at index upto.
    function automatic logic [fta_pkg::CELL_W-1:0] prefix_total(input int unsigned upto);
        int unsigned idx;
        logic [fta_pkg::CELL_W-1:0] acc;
        idx = upto;
        acc = '0;
        while (idx != 0)
        begin
            if (idx < CELL_COUNT)
            begin
                acc = acc + cells[idx];
            end
            idx = idx - (idx & (~idx + 1));
        end
        return acc;
    endfunction

    // Upward walk of an add, bounded by the size in use (capped at the store).
    task automatic apply_add(input logic [fta_pkg::POS_W-1:0] pos,
                             input logic signed [fta_pkg::DELTA_W-1:0] amount);
        int unsigned idx;
        int unsigned limit;
        logic [fta_pkg::CELL_W-1:0] wide;
        limit = (size_now > POSITION_COUNT) ? POSITION_COUNT : 32'(size_now);
        idx = 32'(pos) + 1;
        wide = {{(fta_pkg::CELL_W-fta_pkg::DELTA_W){amount[fta_pkg::DELTA_W-1]}}, amount};
        while (idx <= limit + 1)
        begin
            cells[idx] = cells[idx] + wide;
            idx = idx + (idx & (~idx + 1));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < CELL_COUNT; n++)
            begin
                cells[n] = '0;
            end
            size_now = fta_pkg::SIZE_RESET;
            expected_sums.delete();
            mismatch_count = 0;
            sums_waiting = 0;
        end
        else
        begin
            // A returned sum is matched against the oldest pending one.
            if (rsp.valid && rsp.ready)
            begin
                if (expected_sums.size() == 0)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                    begin
                        $display("unexpected range sum %0d at %0t",
                                 $signed(rsp.range_sum), $realtime);
                    end
                    mismatch_count++;
                end
                else if (rsp.range_sum !== expected_sums[0])
                begin
                    if (mismatch_count < REPORT_LIMIT)
                    begin
                        $display("range_sum mismatch at %0t: expected %0d, got %0d",
                                 $realtime, $signed(expected_sums[0]),
                                 $signed(rsp.range_sum));
                    end
                    mismatch_count++;
                    void'(expected_sums.pop_front());
                end
                else
                begin
                    void'(expected_sums.pop_front());
                end
            end

            // Size register write.
            if (cfg.valid && cfg.ready)
            begin
                size_now = cfg.size_in_use;
            end

            // Accepted request: an add updates the cells, a sum queues its answer.
            if (req.valid && req.ready)
            begin
                if (req.command == fta_pkg::CMD_ADD)
                begin
                    apply_add(req.position, req.delta);
                end
                else
                begin
                    expected_sums.push_back(prefix_total(32'(req.position) + 1)
                                            - prefix_total(32'(req.left_end)));
                end
            end

            sums_waiting = expected_sums.size();
        end
    end

endmodule

/* test/fenwick_tree_add_and_range_sum_core_test.sv */
`timescale 1ns / 1ps

module fenwick_tree_add_and_range_sum_core_test;

    localparam int POSITION_COUNT = 1024;
    localparam int PHASE_COUNT = 8;
    localparam int PHASE_ITEMS = 205;
    localparam int SETTLE_CYCLES = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sink_ready = 1'b1;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatch_count;
    int unsigned sums_waiting;

    fta_req_if req();
    fta_rsp_if rsp();
    fta_cfg_if cfg();

    assign rsp.ready = sink_ready;

    fenwick_tree_add_and_range_sum_core #(
        .MAX_POSITIONS(POSITION_COUNT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .rsp(rsp),
        .cfg(cfg)
    );

    fenwick_sum_checker #(
        .POSITION_COUNT(POSITION_COUNT)
    ) sum_checker (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .rsp(rsp),
        .cfg(cfg),
        .mismatch_count(mismatch_count),
        .sums_waiting(sums_waiting)
    );

    always #5 clk = ~clk;

    // Response side stalls at random according to the current phase.
    always @(negedge clk)
    begin
        sink_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end

    // Size register setting used by each random phase.
    function automatic logic [fta_pkg::SIZE_W-1:0] phase_size(input int k);
        case (k)
            0: return 11'd1024;
            1: return 11'd2047;
            2: return 11'd17;
            3: return 11'd1023;
            4: return 11'd0;
            5: return 11'd1025;
            6: return 11'd1;
            default: return 11'($urandom_range(2047));
        endcase
    endfunction

    // One request, with random idle cycles ahead of it. Returns at a falling edge.
    task automatic send_request(input fta_pkg::cmd_t c, input logic [fta_pkg::POS_W-1:0] p,
                                input logic [fta_pkg::POS_W-1:0] l,
                                input logic signed [fta_pkg::DELTA_W-1:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid = 1'b0;
            @(negedge clk);
        end
        req.valid = 1'b1;
        req.command = c;
        req.position = p;
        req.left_end = l;
        req.delta = d;
        do
        begin
            @(posedge clk);
        end
        while (!req.ready);
        @(negedge clk);
    endtask

    // Wait until every pending sum is back and any add walk has finished.
    task automatic settle();
        req.valid = 1'b0;
        while (sums_waiting != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_size(input logic [fta_pkg::SIZE_W-1:0] s);
        cfg.valid = 1'b1;
        cfg.size_in_use = s;
        do
        begin
            @(posedge clk);
        end
        while (!cfg.ready);
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    // Random request, biased toward positions up to the size in use.
    task automatic send_random(input logic [fta_pkg::SIZE_W-1:0] size_cur);
        fta_pkg::cmd_t c;
        logic [fta_pkg::POS_W-1:0] p;
        logic [fta_pkg::POS_W-1:0] l;
        logic signed [fta_pkg::DELTA_W-1:0] d;
        int unsigned hi;
        int unsigned pick;
        hi = (size_cur > 1023) ? 1023 : 32'(size_cur);
        c = ($urandom_range(99) < 45) ? fta_pkg::CMD_ADD : fta_pkg::CMD_SUM;

        pick = $urandom_range(99);
        if (pick < 40)
        begin
            p = fta_pkg::POS_W'($urandom_range(hi));
        end
        else if (pick < 50)
        begin
            case ($urandom_range(3))
                0: p = '0;
                1: p = '1;
                2: p = fta_pkg::POS_W'(hi);
                default: p = 10'd511;
            endcase
        end
        else
        begin
            p = fta_pkg::POS_W'($urandom_range(1023));
        end

        // Mostly ordered ranges, some single points and some reversed ends.
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            l = fta_pkg::POS_W'($urandom_range(p));
        end
        else if (pick < 70)
        begin
            l = p;
        end
        else if (pick < 85)
        begin
            l = fta_pkg::POS_W'($urandom_range(1023));
        end
        else
        begin
            l = '0;
        end

        if ($urandom_range(99) < 80)
        begin
            d = fta_pkg::DELTA_W'($urandom_range(65535));
        end
        else
        begin
            case ($urandom_range(3))
                0: d = -16'sd32768;
                1: d = 16'sd32767;
                2: d = -16'sd1;
                default: d = 16'sd1;
            endcase
        end
        send_request(c, p, l, d);
    endtask

    initial
    begin
        logic [fta_pkg::SIZE_W-1:0] size_cur;

        req.valid = 1'b0;
        req.command = fta_pkg::CMD_ADD;
        req.position = '0;
        req.left_end = '0;
        req.delta = '0;
        cfg.valid = 1'b0;
        cfg.size_in_use = '0;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Oversized size register: walks are capped at the store size.
        write_size(11'd2047);
        send_request(fta_pkg::CMD_ADD, 10'd0, 10'd1023, -16'sd32768);
        send_request(fta_pkg::CMD_ADD, 10'd1023, 10'd0, 16'sd32767);
        send_request(fta_pkg::CMD_ADD, 10'd511, 10'd0, 16'sd1);
        send_request(fta_pkg::CMD_SUM, 10'd1023, 10'd0, 16'sd0);
        send_request(fta_pkg::CMD_SUM, 10'd1023, 10'd1023, 16'sd0);
        send_request(fta_pkg::CMD_SUM, 10'd0, 10'd0, 16'sd0);
        send_request(fta_pkg::CMD_SUM, 10'd0, 10'd1023, 16'sd0);
        send_request(fta_pkg::CMD_SUM, 10'd511, 10'd512, -16'sd1);

        // Shrunk size: adds past it are dropped, older cells keep their values.
        settle();
        write_size(11'd5);
        send_request(fta_pkg::CMD_ADD, 10'd900, 10'd0, 16'sd1000);
        send_request(fta_pkg::CMD_ADD, 10'd3, 10'd0, -16'sd5);
        send_request(fta_pkg::CMD_SUM, 10'd1023, 10'd0, 16'sd0);
        send_request(fta_pkg::CMD_SUM, 10'd900, 10'd900, 16'sd0);
        send_request(fta_pkg::CMD_SUM, 10'd3, 10'd3, 16'sd0);

        // Zero size: only the first cell can still be reached by an add.
        settle();
        write_size(11'd0);
        send_request(fta_pkg::CMD_ADD, 10'd0, 10'd0, 16'sd7);
        send_request(fta_pkg::CMD_ADD, 10'd1, 10'd0, 16'sd9);
        send_request(fta_pkg::CMD_SUM, 10'd1, 10'd0, 16'sd0);
        send_request(fta_pkg::CMD_SUM, 10'd1, 10'd1, 16'sd0);

        // Random phases, each with its own size setting and one of four idle and stall patterns.
        for (int k = 0; k < PHASE_COUNT; k++)
        begin
            settle();
            case (k % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 58;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 58;
                end
                default:
                begin
                    send_idle_pct = 23;
                    recv_stall_pct = 23;
                end
            endcase
            size_cur = phase_size(k);
            write_size(size_cur);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_random(size_cur);
            end
        end

        settle();
        if (mismatch_count == 0 && sums_waiting == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
